[rtl/core/lhm_pkg.sv]
// ----------------------------------------------------------------------------
// lhm_pkg: shared types and constants of the link health monitor
// Function codes, link status codes, total widths and the delay register set.
// ----------------------------------------------------------------------------
package lhm_pkg;

	// node set
	localparam int NODES  = 4;
	localparam int NODE_W = 2;

	// width of the saturating message and missing totals kept inside
	localparam int TOTAL_BITS  = 32;
	// width of the totals on the result channel
	localparam int OUT_TOTAL_W = 32;
	localparam int SEQ_W       = 8;
	localparam int CNT8_W      = 8;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;

	// item function codes
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REPORT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_TICK   = 2'd2;

	// link status codes
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd0;
	localparam logic [STATUS_W-1:0] ST_GREEN   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_YELLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RED     = 2'd3;

	// configuration register port
	localparam int REG_COUNT = 2 * NODES;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = REG_IDX_W + 2;
	localparam int PDATA_W   = 32;
	localparam int DELAY_W   = 8;
	localparam logic [DELAY_W-1:0] YELLOW_DELAY_RST = 8'd4;
	localparam logic [DELAY_W-1:0] RED_DELAY_RST    = 8'd6;

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// per-node delay settings
	typedef struct packed {
		logic [NODES-1:0][DELAY_W-1:0] yellow_delay;
		logic [NODES-1:0][DELAY_W-1:0] red_delay;
	} cfg_t;

	// classified command held in the queue
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [NODE_W-1:0] node;
		logic [SEQ_W-1:0]  seq;
	} cmd_t;

endpackage

[rtl/core/lhm_if.sv]
// ----------------------------------------------------------------------------
// lhm_if: valid/ready channels of the link health monitor
// Item channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface lhm_item_if;
	logic                          valid;
	logic                          ready;
	logic [lhm_pkg::FUNC_W-1:0]    func;
	logic [lhm_pkg::NODE_W-1:0]    node;
	logic [lhm_pkg::SEQ_W-1:0]     seq_number;

	modport source (output valid, func, node, seq_number, input ready);
	modport sink   (input valid, func, node, seq_number, output ready);
endinterface

interface lhm_result_if;
	logic                            valid;
	logic                            ready;
	logic [lhm_pkg::NODE_W-1:0]      report_node;
	logic [lhm_pkg::STATUS_W-1:0]    link_status;
	logic [lhm_pkg::OUT_TOTAL_W-1:0] missing_total;
	logic [lhm_pkg::OUT_TOTAL_W-1:0] message_total;
	logic [lhm_pkg::CNT8_W-1:0]      yellow_times;
	logic [lhm_pkg::CNT8_W-1:0]      red_times;
	logic                            last;

	modport source (output valid, report_node, link_status, missing_total, message_total,
		yellow_times, red_times, last, input ready);
	modport sink   (input valid, report_node, link_status, missing_total, message_total,
		yellow_times, red_times, last, output ready);
endinterface

[rtl/core/lhm_front.sv]
// ----------------------------------------------------------------------------
// lhm_front: item intake
// Accepts item beats, classifies the function code and pushes valid commands
// into the command queue. Unused function codes are taken and dropped.
// ----------------------------------------------------------------------------
module lhm_front (
	lhm_item_if.sink        item,
	output logic            push_valid,
	input  logic            push_ready,
	output lhm_pkg::cmd_t   push_cmd
);

	logic known_func;

	// classify the function code
	always_comb begin
		unique case (item.func)
			lhm_pkg::FN_CLEAR, lhm_pkg::FN_REPORT, lhm_pkg::FN_TICK: known_func = 1'b1;
			default: known_func = 1'b0;
		endcase
	end

	// hand the command to the queue
	assign item.ready    = push_ready;
	assign push_valid    = item.valid & known_func;
	assign push_cmd.op   = item.func;
	assign push_cmd.node = item.node;
	assign push_cmd.seq  = item.seq_number;

endmodule

[rtl/core/lhm_queue.sv]
// ----------------------------------------------------------------------------
// lhm_queue: command queue
// Small FIFO that decouples item intake from command execution.
// ----------------------------------------------------------------------------
module lhm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lhm_pkg::cmd_t   push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lhm_pkg::cmd_t   pop_cmd
);

	lhm_pkg::cmd_t                  entry_q [lhm_pkg::Q_DEPTH];
	logic [lhm_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [lhm_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [lhm_pkg::Q_CNT_W-1:0]    fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (fill_q != lhm_pkg::Q_CNT_W'(lhm_pkg::Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/lhm_back.sv]
// ----------------------------------------------------------------------------
// lhm_back: command execution
// Holds the per-node statistics and link state machines. Clear and report
// commands do not wait on the output register; a tick steps through the nodes
// one per cycle while it is free, driving one result beat per node into it.
// ----------------------------------------------------------------------------
module lhm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lhm_pkg::cfg_t     cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  lhm_pkg::cmd_t     pop_cmd,
	lhm_result_if.source      result
);

	localparam int TB = lhm_pkg::TOTAL_BITS;

	typedef struct packed {
		logic [lhm_pkg::STATUS_W-1:0] status;
		logic                         first;
		logic [lhm_pkg::SEQ_W-1:0]    last_seq;
		logic [TB-1:0]                count;
		logic [TB-1:0]                prev_count;
		logic [TB-1:0]                missing;
		logic [TB-1:0]                prev_missing;
		logic signed [8:0]            esc;
		logic [lhm_pkg::CNT8_W-1:0]   rec;
		logic [lhm_pkg::CNT8_W-1:0]   yellow_times;
		logic [lhm_pkg::CNT8_W-1:0]   red_times;
	} node_state_t;

	typedef struct packed {
		logic [lhm_pkg::NODE_W-1:0]      report_node;
		logic [lhm_pkg::STATUS_W-1:0]    link_status;
		logic [lhm_pkg::OUT_TOTAL_W-1:0] missing_total;
		logic [lhm_pkg::OUT_TOTAL_W-1:0] message_total;
		logic [lhm_pkg::CNT8_W-1:0]      yellow_times;
		logic [lhm_pkg::CNT8_W-1:0]      red_times;
		logic                            last;
	} result_t;

	localparam node_state_t NODE_RST = '{
		status:       lhm_pkg::ST_UNKNOWN,
		first:        1'b1,
		last_seq:     '0,
		count:        '0,
		prev_count:   '0,
		missing:      '0,
		prev_missing: '0,
		esc:          '0,
		rec:          '0,
		yellow_times: '0,
		red_times:    '0
	};

	localparam logic [TB-1:0] TOTAL_MAX = '1;

	function automatic logic [TB-1:0] inc_total(input logic [TB-1:0] v);
		return (v == TOTAL_MAX) ? TOTAL_MAX : v + 1'b1;
	endfunction

	function automatic logic [7:0] inc8(input logic [7:0] v);
		return (v == 8'hFF) ? 8'hFF : v + 8'd1;
	endfunction

	node_state_t                  node_q [lhm_pkg::NODES];
	logic [lhm_pkg::NODE_W-1:0]   tick_idx_q;
	result_t                      res_q;
	logic                         res_valid_q;

	logic [lhm_pkg::NODE_W-1:0]   sel;
	node_state_t                  cur;
	node_state_t                  rpt_nxt;
	node_state_t                  tck_nxt;
	logic                         out_free;
	logic                         is_tick;
	logic                         exec_tick;
	logic                         exec_other;
	logic                         last_node;
	logic [7:0]                   diff8;
	logic [7:0]                   add8;
	logic [TB:0]                  sum;
	logic                         same_count;
	logic                         same_missing;
	logic                         more_missing;
	logic signed [8:0]            e;
	logic [7:0]                   rc;
	logic [lhm_pkg::DELAY_W-1:0]  yd;
	logic [lhm_pkg::DELAY_W-1:0]  rd;

	// command decode and handshakes
	assign is_tick    = (pop_cmd.op == lhm_pkg::FN_TICK);
	assign out_free   = !res_valid_q || result.ready;
	assign exec_tick  = pop_valid && is_tick && out_free;
	assign exec_other = pop_valid && !is_tick;
	assign last_node  = (tick_idx_q == lhm_pkg::NODE_W'(lhm_pkg::NODES - 1));
	assign pop_ready  = exec_other || (exec_tick && last_node);
	assign sel        = is_tick ? tick_idx_q : pop_cmd.node;
	assign cur        = node_q[sel];
	assign yd         = cfg.yellow_delay[sel];
	assign rd         = cfg.red_delay[sel];

	// report: count the message and adjust the missing total by the sequence gap
	always_comb begin
		rpt_nxt  = cur;
		diff8    = pop_cmd.seq - cur.last_seq;
		add8     = '0;
		sum      = '0;
		rpt_nxt.count    = inc_total(cur.count);
		rpt_nxt.last_seq = pop_cmd.seq;
		if (cur.first) begin
			rpt_nxt.prev_count = inc_total(cur.count);
			rpt_nxt.first      = 1'b0;
		end else if (diff8 == 8'd0) begin
			// repeated number: one less missing, floor at zero
			rpt_nxt.missing = (cur.missing == '0) ? '0 : cur.missing - 1'b1;
		end else begin
			if (pop_cmd.seq < cur.last_seq) begin
				add8 = (diff8 == 8'd1) ? 8'd0 : diff8 - 8'd2;
			end else begin
				add8 = diff8 - 8'd1;
			end
			sum = {1'b0, cur.missing} + (TB + 1)'(add8);
			rpt_nxt.missing = sum[TB] ? TOTAL_MAX : sum[TB-1:0];
		end
	end

	// tick: one step of the node's link state machine
	always_comb begin
		tck_nxt      = cur;
		same_count   = (cur.prev_count == cur.count);
		same_missing = (cur.prev_missing == cur.missing);
		more_missing = (cur.prev_missing < cur.missing);
		e            = cur.esc;
		rc           = cur.rec;
		if (!cur.first) begin
			unique case (cur.status)
				lhm_pkg::ST_GREEN: begin
					if (same_count || more_missing) begin
						tck_nxt.status       = lhm_pkg::ST_YELLOW;
						tck_nxt.yellow_times = inc8(cur.yellow_times);
					end
				end
				lhm_pkg::ST_YELLOW: begin
					if (!same_count) begin
						if (same_missing && (e != -9'sd256)) begin
							e = e - 9'sd1;
						end
					end else if (e != 9'sd255) begin
						e = e + 9'sd1;
					end
					if (e >= $signed({1'b0, yd})) begin
						e = '0;
						tck_nxt.status    = lhm_pkg::ST_RED;
						tck_nxt.red_times = inc8(cur.red_times);
					end else if (e <= 9'sd0) begin
						e = '0;
						tck_nxt.status = lhm_pkg::ST_GREEN;
					end
					tck_nxt.esc = e;
				end
				lhm_pkg::ST_RED: begin
					if (!same_count) begin
						rc = inc8(cur.rec);
					end
					tck_nxt.rec = rc;
					if ((rc >= rd) && same_missing) begin
						tck_nxt.first  = 1'b1;
						tck_nxt.rec    = '0;
						tck_nxt.status = lhm_pkg::ST_YELLOW;
					end
				end
				default: begin
					if (cur.prev_count < cur.count) begin
						if (same_missing) begin
							tck_nxt.status = lhm_pkg::ST_GREEN;
						end
					end else begin
						tck_nxt.status = lhm_pkg::ST_YELLOW;
					end
				end
			endcase
		end
		tck_nxt.prev_count   = cur.count;
		tck_nxt.prev_missing = cur.missing;
	end

	// node state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lhm_pkg::NODES; i++) begin
				node_q[i] <= NODE_RST;
			end
		end else if (exec_other) begin
			unique case (pop_cmd.op)
				lhm_pkg::FN_CLEAR: begin
					for (int i = 0; i < lhm_pkg::NODES; i++) begin
						node_q[i] <= NODE_RST;
					end
				end
				lhm_pkg::FN_REPORT: node_q[sel] <= rpt_nxt;
				default: ;
			endcase
		end else if (exec_tick) begin
			node_q[sel] <= tck_nxt;
		end
	end

	// tick node sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_idx_q <= '0;
		end else if (exec_tick) begin
			tick_idx_q <= tick_idx_q + 1'b1;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_tick) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (exec_tick) begin
			res_q.report_node   <= tick_idx_q;
			res_q.link_status   <= tck_nxt.status;
			res_q.missing_total <= lhm_pkg::OUT_TOTAL_W'(cur.missing);
			res_q.message_total <= lhm_pkg::OUT_TOTAL_W'(cur.count);
			res_q.yellow_times  <= tck_nxt.yellow_times;
			res_q.red_times     <= tck_nxt.red_times;
			res_q.last          <= last_node;
		end
	end

	// result beat
	assign result.valid         = res_valid_q;
	assign result.report_node   = res_q.report_node;
	assign result.link_status   = res_q.link_status;
	assign result.missing_total = res_q.missing_total;
	assign result.message_total = res_q.message_total;
	assign result.yellow_times  = res_q.yellow_times;
	assign result.red_times     = res_q.red_times;
	assign result.last          = res_q.last;

endmodule

[rtl/core/link_health_monitor_unit.sv]
// ----------------------------------------------------------------------------
// link_health_monitor_unit: link health tracker for four remote nodes
// A report beat (func 1) counts a received message for a node and adds the
// sequence gap to its missing total; a clear beat (func 0) resets all
// statistics but keeps the delay registers; func 3 is taken and ignored.
// Clear and report produce no result. A tick beat (func 2) runs each node's
// unknown/green/yellow/red machine and returns four result beats, nodes 0 to
// 3, the last one flagged; the nodes go one after another through the
// shared node-update logic, each waiting while the result register holds a
// beat not yet taken. A two-entry command queue lets item beats be taken while
// the back end works. The yellow and red delays sit in APB registers at byte
// offsets 0x00 (node 0 yellow), 0x04 (node 0 red), and so on up to 0x1C; they
// may be changed only while the block is idle.
// ----------------------------------------------------------------------------
module link_health_monitor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	lhm_item_if.sink                       item,
	lhm_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lhm_pkg::PADDR_W-1:0]    paddr,
	input  logic [lhm_pkg::PDATA_W-1:0]    pwdata,
	output logic [lhm_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	lhm_pkg::cfg_t                  cfg_q;
	logic [lhm_pkg::REG_IDX_W-1:0]  reg_idx;
	logic [lhm_pkg::NODE_W-1:0]     reg_node;
	logic                           reg_wr;

	logic                           push_valid;
	logic                           push_ready;
	lhm_pkg::cmd_t                  push_cmd;
	logic                           pop_valid;
	logic                           pop_ready;
	lhm_pkg::cmd_t                  pop_cmd;

	// register decode: even index yellow delay, odd index red delay
	assign pready   = 1'b1;
	assign reg_idx  = paddr[lhm_pkg::PADDR_W-1:2];
	assign reg_node = reg_idx[lhm_pkg::REG_IDX_W-1:1];
	assign reg_wr   = psel & penable & pwrite & pready;

	// delay registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lhm_pkg::NODES; i++) begin
				cfg_q.yellow_delay[i] <= lhm_pkg::YELLOW_DELAY_RST;
				cfg_q.red_delay[i]    <= lhm_pkg::RED_DELAY_RST;
			end
		end else if (reg_wr) begin
			if (reg_idx[0]) begin
				cfg_q.red_delay[reg_node] <= pwdata[lhm_pkg::DELAY_W-1:0];
			end else begin
				cfg_q.yellow_delay[reg_node] <= pwdata[lhm_pkg::DELAY_W-1:0];
			end
		end
	end

	// register read-back
	assign prdata = reg_idx[0]
		? lhm_pkg::PDATA_W'(cfg_q.red_delay[reg_node])
		: lhm_pkg::PDATA_W'(cfg_q.yellow_delay[reg_node]);

	lhm_front u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	lhm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	lhm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.result    (result)
	);

endmodule
